>>> src/mtg_pkg.sv
// Package with the constants, types and helper functions of the Mersenne Twister generator.
`default_nettype none
package mtg_pkg;

   localparam int STATE_WORDS  = 624;
   localparam int TWIST_OFFSET = 397;
   localparam int ADDR_W       = $clog2(STATE_WORDS);
   localparam int OFFSET_MOD   = TWIST_OFFSET % STATE_WORDS;

   localparam logic [ADDR_W-1:0] LAST_ENTRY  = ADDR_W'(STATE_WORDS - 1);
   localparam logic [ADDR_W:0]   OFFSET_STEP = (ADDR_W + 1)'(OFFSET_MOD);
   localparam logic [ADDR_W:0]   DEPTH_WIDE  = (ADDR_W + 1)'(STATE_WORDS);

   localparam logic [31:0] SEED_MULT     = 32'd69069;
   localparam logic [31:0] TEMPER_B      = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C      = 32'hefc60000;
   localparam logic [31:0] AUTO_SEED     = 32'd4357;
   localparam logic [31:0] ZERO_SEED     = 32'd1234567890;
   localparam logic [31:0] UPPER_BIT     = 32'h80000000;
   localparam logic [31:0] LOWER_BITS    = 32'h7fffffff;
   localparam logic [31:0] MATRIX_RESET  = 32'h9908b0df;

   localparam logic ACTION_SEED = 1'b0;
   localparam logic ACTION_NEXT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_RD_CUR,
      ST_RD_NXT,
      ST_RD_FAR,
      ST_MIX,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RD_POS,
      RD_NEXT,
      RD_FAR
   } rd_sel_type;

   typedef struct packed {
      logic       load_seed;
      logic       auto_seed;
      logic       fill_step;
      rd_sel_type rd_sel;
      logic       latch_cur;
      logic       latch_nxt;
      logic       write_twist;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic fill_last;
      logic seeded;
      logic out_free;
   } status_type;

   function automatic logic [31:0] temper(input logic [31:0] y);
      logic [31:0] t;
      t = y ^ (y >> 11);
      t = t ^ ((t << 7) & TEMPER_B);
      t = t ^ ((t << 15) & TEMPER_C);
      t = t ^ (t >> 18);
      return t;
   endfunction

endpackage
`default_nettype wire

>>> src/mersenne_twister_generator.sv
// Top level of the MT19937 pseudo-random word generator.
// The req_ channel takes one request per handshake: tuser is the action (0 seeds, 1 asks for
// the next word) and tdata the 32-bit seed, which a next request ignores. A zero seed selects
// 1234567890, and every seed is forced odd before it fills the 624-word state store.
// A seed request occupies the block while one store entry is written per cycle by the seed
// multiplier, and gives no response.
// A next request reads three store entries through the single read port of the store, twists
// the current entry, writes it back and tempers it into the response on rsp_; the block takes
// no new request until that response has been moved into the output register.
// A next request that arrives before any seeding first fills the store from seed 4357.
// The twist matrix is written on the csr_ channel, which is always ready; it is to be written
// only while no request is in progress.
// The response is held in an output register; while the receiver stalls, the word waits
// there and the block still takes requests but holds its next response back.
// Synchronous reset empties the output register, marks the generator as unseeded and
// restores the twist matrix to 0x9908B0DF.
`default_nettype none
module mersenne_twister_generator (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] seed_value
   input  wire logic        req_tuser,   // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] random_word
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_wdata
);
   import mtg_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mtg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tuser (req_tuser),
      .status    (status),
      .cmd       (cmd)
   );

   mtg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .seed_value(req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire

>>> src/mtg_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module mtg_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 624
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

>>> src/mtg_ctrl.sv
// Controller state machine that sequences seeding, state reads, the twist and output.
`default_nettype none
module mtg_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic               req_tuser,
   input  wire mtg_pkg::status_type status,
   output mtg_pkg::cmd_type        cmd
);
   import mtg_pkg::*;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_tuser == ACTION_SEED) begin
                  state_in = ST_FILL;
                  pend_in  = 1'b0;
               end else if (!status.seeded) begin
                  state_in = ST_FILL;
                  pend_in  = 1'b1;
               end else begin
                  state_in = ST_RD_CUR;
               end
            end
         end
         ST_FILL: begin
            if (status.fill_last) begin
               state_in = pend_ff ? ST_RD_CUR : ST_IDLE;
               pend_in  = 1'b0;
            end
         end
         ST_RD_CUR: state_in = ST_RD_NXT;
         ST_RD_NXT: state_in = ST_RD_FAR;
         ST_RD_FAR: state_in = ST_MIX;
         ST_MIX:    state_in = ST_EMIT;
         ST_EMIT: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_POS;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_seed = accept && ((req_tuser == ACTION_SEED) || !status.seeded);
            cmd.auto_seed = (req_tuser == ACTION_NEXT);
         end
         ST_FILL:   cmd.fill_step = 1'b1;
         ST_RD_CUR: cmd.rd_sel = RD_POS;
         ST_RD_NXT: begin
            cmd.rd_sel    = RD_NEXT;
            cmd.latch_cur = 1'b1;
         end
         ST_RD_FAR: begin
            cmd.rd_sel    = RD_FAR;
            cmd.latch_nxt = 1'b1;
         end
         ST_MIX:    cmd.write_twist = 1'b1;
         ST_EMIT:   cmd.emit = status.out_free;
         default:   cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

>>> src/mtg_datapath.sv
// Datapath with the state store, seed multiplier, twist, tempering and output register.
`default_nettype none
module mtg_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mtg_pkg::cmd_type cmd,
   output mtg_pkg::status_type   status,
   input  wire logic [31:0]      seed_value,
   input  wire logic             csr_write,
   input  wire logic [31:0]      csr_wdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [31:0]           rsp_tdata
);
   import mtg_pkg::*;

   logic [31:0]       matrix_ff, matrix_in;
   logic [31:0]       block_matrix_ff;
   logic [31:0]       x_ff, x_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;
   logic              seeded_ff, seeded_in;
   logic [31:0]       cur_ff, nxt_ff, word_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff;

   logic [31:0]       product;
   logic [31:0]       seed_pick;
   logic [ADDR_W-1:0] pos_next;
   logic [ADDR_W:0]   far_sum;
   logic [ADDR_W-1:0] far_addr;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic [31:0]       rd_data, wr_data, mix, twisted, twist_key;
   logic              wr_en;

   mtg_ram #(
      .WIDTH(32),
      .DEPTH(STATE_WORDS)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign pos_next = (pos_ff == LAST_ENTRY) ? '0 : pos_ff + 1'b1;
   assign far_sum  = {1'b0, pos_ff} + OFFSET_STEP;
   assign far_addr = (far_sum >= DEPTH_WIDE) ? ADDR_W'(far_sum - DEPTH_WIDE)
                                             : far_sum[ADDR_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_POS:  rd_addr = pos_ff;
         RD_NEXT: rd_addr = pos_next;
         RD_FAR:  rd_addr = far_addr;
         default: rd_addr = pos_ff;
      endcase
   end

   // The matrix in force when entry 0 is twisted serves the whole block of words.
   assign twist_key = (pos_ff == '0) ? matrix_ff : block_matrix_ff;

   assign mix     = (cur_ff & UPPER_BIT) | (nxt_ff & LOWER_BITS);
   assign twisted = rd_data ^ (mix >> 1) ^ (nxt_ff[0] ? twist_key : 32'd0);

   assign wr_en   = cmd.fill_step || cmd.write_twist;
   assign wr_addr = cmd.fill_step ? idx_ff : pos_ff;
   assign wr_data = cmd.fill_step ? x_ff : twisted;

   assign product   = x_ff * SEED_MULT;
   assign seed_pick = cmd.auto_seed ? AUTO_SEED
                    : ((seed_value == 32'd0) ? ZERO_SEED : seed_value);

   always_comb begin
      matrix_in    = csr_write ? csr_wdata : matrix_ff;
      x_in         = x_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      seeded_in    = seeded_ff;
      rsp_valid_in = rsp_tready ? 1'b0 : rsp_valid_ff;
      if (cmd.load_seed) begin
         x_in   = seed_pick | 32'd1;
         idx_in = '0;
      end
      if (cmd.fill_step) begin
         x_in   = product;
         idx_in = idx_ff + 1'b1;
         if (idx_ff == LAST_ENTRY) begin
            pos_in    = '0;
            seeded_in = 1'b1;
         end
      end
      if (cmd.emit) begin
         pos_in       = pos_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff    <= MATRIX_RESET;
         pos_ff       <= '0;
         seeded_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         matrix_ff    <= matrix_in;
         pos_ff       <= pos_in;
         seeded_ff    <= seeded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      idx_ff <= idx_in;
      if (cmd.latch_cur) begin
         cur_ff <= rd_data;
      end
      if (cmd.latch_nxt) begin
         nxt_ff <= rd_data;
      end
      if (cmd.write_twist) begin
         word_ff <= twisted;
      end
      if (cmd.write_twist && (pos_ff == '0)) begin
         block_matrix_ff <= matrix_ff;
      end
      if (cmd.emit) begin
         rsp_data_ff <= temper(word_ff);
      end
   end

   assign status.fill_last = (idx_ff == LAST_ENTRY);
   assign status.seeded    = seeded_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

>>> src/mtg_checker.sv
// Port-level checker for the generator and the bind that attaches it to the top level.
`default_nettype none
module mtg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // A response is never presented in the cycle after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid just after reset");

   // Each request keeps the block busy, so req_tready drops once a request is taken.
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken in two consecutive cycles");

   // No response can follow a request in the very next cycle.
   a_no_instant_response: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("response appeared one cycle after its request");

   // A stalled response stays presented with the same word.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response dropped or changed");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
`default_nettype wire
